// ===== design/owss_pkg.sv =====
// owss_pkg: shared types and constants of the one-wire slave slot engine
// no dependencies; used by every module of the block but owss_fifo, and by the checker
package owss_pkg;

	// classified command carried from the front to the engine
	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_READ   = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_SEARCH = 3'd3,
		CMD_MATCH  = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_LOW   = 4'd1,
		PH_WAIT  = 4'd2,
		PH_RSAMP = 4'd3,
		PH_RTAIL = 4'd4,
		PH_RREL  = 4'd5,
		PH_WBIT  = 4'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_RESET      = 3'd1,
		EV_SHORT      = 3'd2,
		EV_BYTE_READ  = 3'd3,
		EV_BYTE_WRITE = 3'd4,
		EV_MATCH      = 3'd5,
		EV_MISMATCH   = 3'd6,
		EV_BUS_ERROR  = 3'd7
	} event_t;

	typedef enum logic [2:0] {
		CFG_SAMPLE_DELAY    = 3'd0,
		CFG_READ_TAIL       = 3'd1,
		CFG_RELEASE_TIMEOUT = 3'd2,
		CFG_ZERO_HOLD       = 3'd3,
		CFG_WRITE_SLOT      = 3'd4,
		CFG_RESET_MIN       = 3'd5,
		CFG_RESET_MAX       = 3'd6
	} cfg_idx_t;

	localparam logic [7:0] RST_SAMPLE_DELAY    = 8'd10;
	localparam logic [7:0] RST_READ_TAIL       = 8'd35;
	localparam logic [9:0] RST_RELEASE_TIMEOUT = 10'd40;
	localparam logic [7:0] RST_ZERO_HOLD       = 8'd17;
	localparam logic [7:0] RST_WRITE_SLOT      = 8'd55;
	localparam logic [9:0] RST_RESET_MIN       = 10'd122;
	localparam logic [9:0] RST_RESET_MAX       = 10'd680;

	typedef struct packed {
		cmd_t       cmd;
		logic       line;
		logic [7:0] data_byte;
		logic       ref_bit;
	} item_t;

	typedef struct packed {
		logic       drive_low;
		event_t     event_res;
		logic [7:0] rx_byte;
		logic       busy_res;
	} result_t;

endpackage

// ===== design/owss_fifo.sv =====
// owss_fifo: small register queue with push/full and pop/empty sides
// no dependencies; used for the request queue and the result queue
module owss_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/owss_front.sv =====
// owss_front: accepts tick requests, classifies the mode and queues them
// depends on owss_pkg and owss_fifo
module owss_front #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [2:0]     mode,
	input  logic           line,
	input  logic [7:0]     data_byte,
	input  logic           ref_bit,
	output owss_pkg::item_t item,
	output logic           item_valid,
	input  logic           item_take
);

	owss_pkg::item_t in_item;
	logic            q_empty;

	// unused modes behave as a plain tick
	always_comb begin
		in_item.line      = line;
		in_item.data_byte = data_byte;
		in_item.ref_bit   = ref_bit;
		if (mode inside {[3'd1:3'd4]}) begin
			in_item.cmd = owss_pkg::cmd_t'(mode);
		end else begin
			in_item.cmd = owss_pkg::CMD_TICK;
		end
	end

	owss_fifo #(
		.WIDTH($bits(owss_pkg::item_t)),
		.DEPTH(DEPTH)
	) u_req_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(in_item),
		.full   (full),
		.rd_en  (item_take),
		.rd_data(item),
		.empty  (q_empty)
	);

	assign item_valid = !q_empty;

endmodule

// ===== design/owss_engine.sv =====
// owss_engine: slot timing state machine, one queued tick per cycle while the result queue has room
// depends on owss_pkg; fed by owss_front, drains into the result queue
module owss_engine #(
	parameter int TIMER_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	input  owss_pkg::item_t   item,
	input  logic              item_valid,
	output logic              item_take,
	input  logic              res_full,
	output owss_pkg::result_t res
);

	localparam int TB = TIMER_BITS;
	localparam int CW = (TB > 10) ? TB : 10;
	localparam logic [TB-1:0] TMAX = '1;

	logic [7:0] sample_delay_q, read_tail_q, zero_hold_q, write_slot_q;
	logic [9:0] release_timeout_q, reset_min_q, reset_max_q;

	owss_pkg::phase_t phase_q, ph;
	owss_pkg::cmd_t   cmd_q, cm;
	logic [TB-1:0]    tick_q, tc;
	logic [7:0]       shift_q, sh;
	logic [2:0]       bit_q, bi;
	logic [1:0]       step_q, ss;
	logic             target_q, tg, sampled_q, sb, prev_q;

	logic [TB-1:0] lim_sd, lim_rt, lim_to, lim_zh, lim_ws, wend;
	logic          fall, fin, step;

	// slot timing registers clamped to [1, timer max]; the reset bounds are compared raw
	function automatic logic [TB-1:0] lim(input logic [9:0] v);
		logic [TB-1:0] r;
		if (v == '0) begin
			r = TB'(1);
		end else if (CW'(v) > CW'(TMAX)) begin
			r = TMAX;
		end else begin
			r = TB'(v);
		end
		return r;
	endfunction

	function automatic logic slot_bit(input owss_pkg::cmd_t c, input logic [7:0] s,
		input logic [2:0] b, input logic [1:0] st, input logic t);
		logic r;
		if (c == owss_pkg::CMD_WRITE) begin
			r = s[b];
		end else if (st == 2'd0) begin
			r = t;
		end else begin
			r = ~t;
		end
		return r;
	endfunction

	assign lim_sd = lim({2'b00, sample_delay_q});
	assign lim_rt = lim({2'b00, read_tail_q});
	assign lim_to = lim(release_timeout_q);
	assign lim_zh = lim({2'b00, zero_hold_q});
	assign lim_ws = lim({2'b00, write_slot_q});
	assign wend   = (lim_zh > lim_ws) ? lim_zh : lim_ws;

	assign step      = item_valid && !res_full;
	assign item_take = step;

	always_comb begin
		ph  = phase_q;
		cm  = cmd_q;
		tc  = tick_q;
		sh  = shift_q;
		bi  = bit_q;
		ss  = step_q;
		tg  = target_q;
		sb  = sampled_q;
		fin = 1'b0;
		res.drive_low = 1'b0;
		res.event_res = owss_pkg::EV_NONE;
		res.rx_byte   = 8'd0;
		fall = prev_q && !item.line;

		// a command starts only from idle or a timed low pulse
		if ((ph == owss_pkg::PH_IDLE || ph == owss_pkg::PH_LOW) &&
			item.cmd != owss_pkg::CMD_TICK) begin
			cm = item.cmd;
			bi = 3'd0;
			ss = 2'd0;
			tg = item.ref_bit;
			sh = (item.cmd == owss_pkg::CMD_WRITE) ? item.data_byte : 8'd0;
			ph = owss_pkg::PH_WAIT;
			tc = '0;
		end

		case (ph)
			owss_pkg::PH_IDLE: begin
				if (fall) begin
					ph = owss_pkg::PH_LOW;
					tc = TB'(1);
				end
			end
			owss_pkg::PH_LOW: begin
				if (item.line) begin
					if (CW'(tc) >= CW'(reset_min_q) && CW'(tc) <= CW'(reset_max_q)) begin
						res.event_res = owss_pkg::EV_RESET;
					end else begin
						res.event_res = owss_pkg::EV_SHORT;
					end
					ph = owss_pkg::PH_IDLE;
					tc = '0;
				end else if (tc != TMAX) begin
					tc = tc + 1'b1;
				end
			end
			owss_pkg::PH_WAIT: begin
				if (fall) begin
					tc = '0;
					if (cm == owss_pkg::CMD_READ || cm == owss_pkg::CMD_MATCH ||
						(cm == owss_pkg::CMD_SEARCH && ss >= 2'd2)) begin
						ph = owss_pkg::PH_RSAMP;
					end else begin
						ph = owss_pkg::PH_WBIT;
						res.drive_low = ~slot_bit(cm, sh, bi, ss, tg);
					end
				end
			end
			owss_pkg::PH_RSAMP: begin
				if (tc != TMAX) tc = tc + 1'b1;
				if (tc >= lim_sd) begin
					sb = item.line;
					ph = owss_pkg::PH_RTAIL;
					tc = '0;
				end
			end
			owss_pkg::PH_RTAIL: begin
				if (tc != TMAX) tc = tc + 1'b1;
				if (tc >= lim_rt) begin
					if (item.line) begin
						fin = 1'b1;
					end else begin
						ph = owss_pkg::PH_RREL;
						tc = '0;
					end
				end
			end
			owss_pkg::PH_RREL: begin
				if (item.line) begin
					fin = 1'b1;
				end else begin
					if (tc != TMAX) tc = tc + 1'b1;
					// master held the line: abort and time it as a possible reset pulse
					if (tc >= lim_to) begin
						res.event_res = owss_pkg::EV_BUS_ERROR;
						cm = owss_pkg::CMD_TICK;
						ph = owss_pkg::PH_LOW;
						tc = TB'(1);
					end
				end
			end
			owss_pkg::PH_WBIT: begin
				if (tc != TMAX) tc = tc + 1'b1;
				if (tc >= wend) begin
					fin = 1'b1;
				end else begin
					res.drive_low = !slot_bit(cm, sh, bi, ss, tg) && (tc < lim_zh);
				end
			end
			default: begin
				ph = owss_pkg::PH_IDLE;
				tc = '0;
				cm = owss_pkg::CMD_TICK;
			end
		endcase

		// end of a bit slot
		if (fin) begin
			tc = '0;
			ph = owss_pkg::PH_WAIT;
			case (cm)
				owss_pkg::CMD_READ: begin
					sh = {sb, sh[7:1]};
					if (bi == 3'd7) begin
						res.event_res = owss_pkg::EV_BYTE_READ;
						res.rx_byte   = sh;
						ph = owss_pkg::PH_IDLE;
						cm = owss_pkg::CMD_TICK;
					end else begin
						bi = bi + 1'b1;
					end
				end
				owss_pkg::CMD_WRITE: begin
					if (bi == 3'd7) begin
						res.event_res = owss_pkg::EV_BYTE_WRITE;
						ph = owss_pkg::PH_IDLE;
						cm = owss_pkg::CMD_TICK;
					end else begin
						bi = bi + 1'b1;
					end
				end
				default: begin
					if (cm == owss_pkg::CMD_SEARCH && ss < 2'd2) begin
						ss = ss + 1'b1;
					end else begin
						res.event_res = (sb == tg) ? owss_pkg::EV_MATCH : owss_pkg::EV_MISMATCH;
						ph = owss_pkg::PH_IDLE;
						cm = owss_pkg::CMD_TICK;
					end
				end
			endcase
		end

		res.busy_res = (ph inside {[owss_pkg::PH_WAIT:owss_pkg::PH_WBIT]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= owss_pkg::PH_IDLE;
			cmd_q     <= owss_pkg::CMD_TICK;
			tick_q    <= '0;
			shift_q   <= 8'd0;
			bit_q     <= 3'd0;
			step_q    <= 2'd0;
			target_q  <= 1'b0;
			sampled_q <= 1'b0;
			prev_q    <= 1'b1;
		end else if (step) begin
			phase_q   <= ph;
			cmd_q     <= cm;
			tick_q    <= tc;
			shift_q   <= sh;
			bit_q     <= bi;
			step_q    <= ss;
			target_q  <= tg;
			sampled_q <= sb;
			prev_q    <= item.line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_delay_q    <= owss_pkg::RST_SAMPLE_DELAY;
			read_tail_q       <= owss_pkg::RST_READ_TAIL;
			release_timeout_q <= owss_pkg::RST_RELEASE_TIMEOUT;
			zero_hold_q       <= owss_pkg::RST_ZERO_HOLD;
			write_slot_q      <= owss_pkg::RST_WRITE_SLOT;
			reset_min_q       <= owss_pkg::RST_RESET_MIN;
			reset_max_q       <= owss_pkg::RST_RESET_MAX;
		end else if (cfg_we) begin
			case (owss_pkg::cfg_idx_t'(cfg_index))
				owss_pkg::CFG_SAMPLE_DELAY:    sample_delay_q    <= cfg_data[7:0];
				owss_pkg::CFG_READ_TAIL:       read_tail_q       <= cfg_data[7:0];
				owss_pkg::CFG_RELEASE_TIMEOUT: release_timeout_q <= cfg_data;
				owss_pkg::CFG_ZERO_HOLD:       zero_hold_q       <= cfg_data[7:0];
				owss_pkg::CFG_WRITE_SLOT:      write_slot_q      <= cfg_data[7:0];
				owss_pkg::CFG_RESET_MIN:       reset_min_q       <= cfg_data;
				owss_pkg::CFG_RESET_MAX:       reset_max_q       <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/one_wire_slave_slot_engine.sv =====
// a request waits in the request queue; its result is written to the result queue as the engine takes it
// throughput: one tick request per cycle while the result queue has room, one slot engine step per request
// the request queue and the result queue let either side stall on its own
// reset: arst_n clears both queues, puts the engine in idle with the line seen
// released, and loads the timing registers with their default values
// depends on owss_pkg, owss_front, owss_engine and owss_fifo
module one_wire_slave_slot_engine #(
	parameter int TIMER_BITS  = 10,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	// request side
	input  logic       push,
	output logic       full,
	input  logic [2:0] mode,
	input  logic       line,
	input  logic [7:0] data_byte,
	input  logic       ref_bit,
	// result side
	output logic       empty,
	input  logic       pop,
	output logic       drive_low,
	output logic [2:0] event_res,
	output logic [7:0] rx_byte,
	output logic       busy_res,
	// configuration writes, only while idle
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data
);

	owss_pkg::item_t   item;
	owss_pkg::result_t res, res_head;
	logic              item_valid, item_take, res_full;

	// front: classify mode and queue the request
	owss_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.line      (line),
		.data_byte (data_byte),
		.ref_bit   (ref_bit),
		.item      (item),
		.item_valid(item_valid),
		.item_take (item_take)
	);

	// back: one slot timing step per request, stalls only on a full result queue
	owss_engine #(
		.TIMER_BITS(TIMER_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.item_valid(item_valid),
		.item_take (item_take),
		.res_full  (res_full),
		.res       (res)
	);

	// results wait here until popped; a request is taken from the front
	// exactly when its result is written
	owss_fifo #(
		.WIDTH($bits(owss_pkg::result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (item_take),
		.wr_data(res),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_head),
		.empty  (empty)
	);

	assign drive_low = res_head.drive_low;
	assign event_res = res_head.event_res;
	assign rx_byte   = res_head.rx_byte;
	assign busy_res  = res_head.busy_res;

endmodule

// ===== design/owss_checker.sv =====
// owss_checker: port-level checks of the result side of the slot engine
// depends on owss_pkg; bound to one_wire_slave_slot_engine below
module owss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       drive_low,
	input logic [2:0] event_res,
	input logic [7:0] rx_byte,
	input logic       busy_res
);

	// received byte is only carried by a byte read event
	a_rx_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_res != owss_pkg::EV_BYTE_READ) |-> (rx_byte == 8'd0))
		else $error("rx_byte nonzero without byte read event");

	// the slave pulls the line only inside a command
	a_drive_in_command: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && drive_low) |-> busy_res)
		else $error("drive_low while not busy");

	// every reported event leaves the engine without an active command
	a_event_ends_command: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_res != owss_pkg::EV_NONE) |-> !busy_res)
		else $error("event reported while still busy");

	// a waiting result stays until popped
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped without pop");

endmodule

bind one_wire_slave_slot_engine owss_checker u_owss_checker (.*);

// ===== dv/tb_one_wire_slave_slot_engine.sv =====
// tb_one_wire_slave_slot_engine: self-checking bench for the one-wire slave slot engine
// predicts every tick result in-bench and checks it field by field
// depends on owss_pkg and one_wire_slave_slot_engine
`timescale 1ns / 1ps

module tb_one_wire_slave_slot_engine;

	localparam int TIMER_BITS = 10;
	localparam logic [9:0] TICK_MAX = 10'h3FF;
	// stop the random part once about this many ticks have been queued
	localparam int RANDOM_TICKS = 240;
	localparam int RANDOM_BATCH = 80;
	// long receiver hold-off: starts after this many results, its counter is loaded with HOLD_LEN
	localparam int HOLD_AT = 150;
	localparam int HOLD_LEN = 400;
	// the hold-off only starts while this many requests are still pending
	localparam int HOLD_BACKLOG = 32;

	// one bus tick request as presented on the request ports
	typedef struct packed {
		logic [2:0] mode;
		logic       line;
		logic [7:0] data_byte;
		logic       ref_bit;
	} tick_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [2:0] mode = owss_pkg::CMD_TICK;
	logic       line = 1'b1;
	logic [7:0] data_byte = 8'h00;
	logic       ref_bit = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic       drive_low;
	logic [2:0] event_res;
	logic [7:0] rx_byte;
	logic       busy_res;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = owss_pkg::CFG_SAMPLE_DELAY;
	logic [9:0] cfg_data = 10'd0;

	one_wire_slave_slot_engine #(
		.TIMER_BITS(TIMER_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.line(line),
		.data_byte(data_byte),
		.ref_bit(ref_bit),
		.empty(empty),
		.pop(pop),
		.drive_low(drive_low),
		.event_res(event_res),
		.rx_byte(rx_byte),
		.busy_res(busy_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// requests waiting to be offered, and predicted results waiting to be popped
	tick_req_t         bus_ticks[$];
	owss_pkg::result_t slot_results[$];

	int failures = 0;
	int results_seen = 0;
	int cycle_no = 0;
	int ticks_queued = 0;
	// percent of ticks that carry a random mode instead of a plain tick
	int noise_pct = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// a stretch of the run with no random idling on either side
	wire calm = cycle_no >= 800 && cycle_no < 1100;

	// bench copy of the timing registers, as the block holds them
	logic [9:0] timing [7];

	// predicted engine state
	owss_pkg::phase_t eng_phase = owss_pkg::PH_IDLE;
	logic [9:0] eng_ticks = '0;
	logic [7:0] eng_shift = '0;
	logic [2:0] eng_bit = '0;
	logic [2:0] eng_cmd = owss_pkg::CMD_TICK;
	logic       eng_target = 1'b0;
	logic       eng_sample = 1'b0;
	logic [1:0] eng_search = '0;
	logic       eng_prev = 1'b1;

	// zero delays are used as one tick; 10-bit registers never exceed the timer
	function automatic logic [9:0] eff_ticks(owss_pkg::cfg_idx_t idx);
		return (timing[idx] == 10'd0) ? 10'd1 : timing[idx];
	endfunction

	// level the slave sends in the current write slot
	function automatic logic slot_level();
		if (eng_cmd == owss_pkg::CMD_WRITE)
			return eng_shift[eng_bit];
		return (eng_search == 2'd0) ? eng_target : ~eng_target;
	endfunction

	// saturating slot timer
	task automatic count_tick();
		if (eng_ticks != TICK_MAX)
			eng_ticks = eng_ticks + 10'd1;
	endtask

	task automatic retire_engine();
		eng_phase = owss_pkg::PH_IDLE;
		eng_ticks = '0;
		eng_cmd = owss_pkg::CMD_TICK;
	endtask

	// end of one bit slot: shift in, count bits, or conclude the command
	task automatic close_bit(inout owss_pkg::event_t ev, inout logic [7:0] rx);
		eng_ticks = '0;
		eng_phase = owss_pkg::PH_WAIT;
		case (eng_cmd)
			owss_pkg::CMD_READ: begin
				eng_shift = {eng_sample, eng_shift[7:1]};
				if (eng_bit == 3'd7) begin
					ev = owss_pkg::EV_BYTE_READ;
					rx = eng_shift;
					retire_engine();
				end else
					eng_bit = eng_bit + 3'd1;
			end
			owss_pkg::CMD_WRITE: begin
				if (eng_bit == 3'd7) begin
					ev = owss_pkg::EV_BYTE_WRITE;
					retire_engine();
				end else
					eng_bit = eng_bit + 3'd1;
			end
			default: begin
				if (eng_cmd == owss_pkg::CMD_SEARCH && eng_search < 2'd2)
					eng_search = eng_search + 2'd1;
				else begin
					ev = (eng_sample == eng_target) ? owss_pkg::EV_MATCH :
						owss_pkg::EV_MISMATCH;
					retire_engine();
				end
			end
		endcase
	endtask

	// one bus tick through the predicted engine
	task automatic engine_step(input tick_req_t r, output owss_pkg::result_t res);
		logic             drv;
		owss_pkg::event_t ev;
		logic [7:0]       rx;
		logic [9:0]       slot_end;
		drv = 1'b0;
		ev = owss_pkg::EV_NONE;
		rx = '0;
		// commands only start from idle or a timed low pulse; modes past match are plain ticks
		if ((eng_phase == owss_pkg::PH_IDLE || eng_phase == owss_pkg::PH_LOW) &&
				r.mode >= owss_pkg::CMD_READ && r.mode <= owss_pkg::CMD_MATCH) begin
			eng_cmd = r.mode;
			eng_bit = '0;
			eng_search = '0;
			eng_target = r.ref_bit;
			eng_shift = (r.mode == owss_pkg::CMD_WRITE) ? r.data_byte : 8'h00;
			eng_phase = owss_pkg::PH_WAIT;
			eng_ticks = '0;
		end
		case (eng_phase)
			owss_pkg::PH_IDLE: begin
				if (eng_prev && !r.line) begin
					eng_phase = owss_pkg::PH_LOW;
					eng_ticks = 10'd1;
				end
			end
			owss_pkg::PH_LOW: begin
				if (r.line) begin
					// bounds taken raw: min above max never gives a reset
					ev = (eng_ticks >= timing[owss_pkg::CFG_RESET_MIN] &&
						eng_ticks <= timing[owss_pkg::CFG_RESET_MAX]) ?
						owss_pkg::EV_RESET : owss_pkg::EV_SHORT;
					eng_phase = owss_pkg::PH_IDLE;
					eng_ticks = '0;
				end else
					count_tick();
			end
			owss_pkg::PH_WAIT: begin
				if (eng_prev && !r.line) begin
					eng_ticks = '0;
					if (eng_cmd == owss_pkg::CMD_READ || eng_cmd == owss_pkg::CMD_MATCH ||
							(eng_cmd == owss_pkg::CMD_SEARCH && eng_search >= 2'd2))
						eng_phase = owss_pkg::PH_RSAMP;
					else begin
						eng_phase = owss_pkg::PH_WBIT;
						drv = ~slot_level();
					end
				end
			end
			owss_pkg::PH_RSAMP: begin
				count_tick();
				if (eng_ticks >= eff_ticks(owss_pkg::CFG_SAMPLE_DELAY)) begin
					eng_sample = r.line;
					eng_phase = owss_pkg::PH_RTAIL;
					eng_ticks = '0;
				end
			end
			owss_pkg::PH_RTAIL: begin
				count_tick();
				if (eng_ticks >= eff_ticks(owss_pkg::CFG_READ_TAIL)) begin
					if (r.line)
						close_bit(ev, rx);
					else begin
						eng_phase = owss_pkg::PH_RREL;
						eng_ticks = '0;
					end
				end
			end
			owss_pkg::PH_RREL: begin
				if (r.line)
					close_bit(ev, rx);
				else begin
					count_tick();
					if (eng_ticks >= eff_ticks(owss_pkg::CFG_RELEASE_TIMEOUT)) begin
						// bus error: abort, then time the low line as a possible reset
						ev = owss_pkg::EV_BUS_ERROR;
						rx = '0;
						eng_cmd = owss_pkg::CMD_TICK;
						eng_phase = owss_pkg::PH_LOW;
						eng_ticks = 10'd1;
					end
				end
			end
			owss_pkg::PH_WBIT: begin
				count_tick();
				slot_end = eff_ticks(owss_pkg::CFG_WRITE_SLOT);
				if (eff_ticks(owss_pkg::CFG_ZERO_HOLD) > slot_end)
					slot_end = eff_ticks(owss_pkg::CFG_ZERO_HOLD);
				if (eng_ticks >= slot_end)
					close_bit(ev, rx);
				else
					drv = (slot_level() == 1'b0 &&
						eng_ticks < eff_ticks(owss_pkg::CFG_ZERO_HOLD));
			end
			default: retire_engine();
		endcase
		eng_prev = r.line;
		res.drive_low = drv;
		res.event_res = ev;
		res.rx_byte = rx;
		res.busy_res = (eng_phase >= owss_pkg::PH_WAIT && eng_phase <= owss_pkg::PH_WBIT);
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic add_tick(input logic [2:0] m, input logic lv, input logic [7:0] d,
			input logic rb);
		tick_req_t t;
		t.mode = m;
		t.line = lv;
		t.data_byte = d;
		t.ref_bit = rb;
		bus_ticks.push_back(t);
		ticks_queued++;
	endtask

	// hold the line at one level; a few ticks may carry a stray mode
	task automatic add_level(input logic lv, input int n);
		repeat (n) begin
			if ($urandom_range(0, 99) < noise_pct)
				add_tick(3'($urandom_range(0, 7)), lv, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			else
				add_tick(owss_pkg::CMD_TICK, lv, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
	endtask

	// master pulls low for lo ticks, then releases for hi ticks
	task automatic add_pulse(input int lo, input int hi);
		add_level(1'b0, lo);
		add_level(1'b1, hi);
	endtask

	// ticks from a slot edge until any kind of slot is surely over
	function automatic int slot_span();
		int rd, wr;
		rd = int'(eff_ticks(owss_pkg::CFG_SAMPLE_DELAY)) +
			int'(eff_ticks(owss_pkg::CFG_READ_TAIL));
		wr = (eff_ticks(owss_pkg::CFG_WRITE_SLOT) > eff_ticks(owss_pkg::CFG_ZERO_HOLD)) ?
			int'(eff_ticks(owss_pkg::CFG_WRITE_SLOT)) :
			int'(eff_ticks(owss_pkg::CFG_ZERO_HOLD));
		return ((rd > wr) ? rd : wr) + 2;
	endfunction

	// low time of a master slot: a one, a zero, a late release, or a stuck line
	function automatic int pick_low();
		int sd, rt, rto, k;
		sd = int'(eff_ticks(owss_pkg::CFG_SAMPLE_DELAY));
		rt = int'(eff_ticks(owss_pkg::CFG_READ_TAIL));
		rto = int'(eff_ticks(owss_pkg::CFG_RELEASE_TIMEOUT));
		k = int'($urandom_range(0, 99));
		if (k < 40)
			return int'($urandom_range(1, sd));
		if (k < 80)
			return int'($urandom_range(sd + 1, sd + rt));
		if (k < 92)
			return int'($urandom_range(sd + rt + 1, sd + rt + rto));
		return int'($urandom_range(sd + rt + rto, sd + rt + rto + 3));
	endfunction

	// pulse length around the reset bounds, or anywhere up to just past the higher one
	function automatic int pick_reset_len();
		int lo_b, hi_b;
		lo_b = int'(timing[owss_pkg::CFG_RESET_MIN]);
		hi_b = int'(timing[owss_pkg::CFG_RESET_MAX]);
		case ($urandom_range(0, 2))
			0: return int'($urandom_range((lo_b > 1) ? lo_b - 1 : 1, lo_b + 1));
			1: return int'($urandom_range((hi_b > 1) ? hi_b - 1 : 1, hi_b + 1));
			default: return int'($urandom_range(1, ((lo_b > hi_b) ? lo_b : hi_b) + 3));
		endcase
	endfunction

	// a command request followed by as many master slots as it needs
	task automatic add_command(input logic [2:0] m, input logic lv);
		int slots;
		slots = (m == owss_pkg::CMD_READ || m == owss_pkg::CMD_WRITE) ? 8 :
			(m == owss_pkg::CMD_SEARCH) ? 3 : 1;
		add_tick(m, lv, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		repeat (slots)
			add_pulse(pick_low(), int'($urandom_range(1, slot_span())));
	endtask

	task automatic write_reg(input owss_pkg::cfg_idx_t idx, input logic [9:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		// the 8-bit registers keep only the low byte
		if (idx == owss_pkg::CFG_RELEASE_TIMEOUT || idx == owss_pkg::CFG_RESET_MIN ||
				idx == owss_pkg::CFG_RESET_MAX)
			timing[idx] = val;
		else
			timing[idx] = {2'b00, val[7:0]};
	endtask

	task automatic load_timing(input logic [9:0] sd, input logic [9:0] rt,
			input logic [9:0] rto, input logic [9:0] zh, input logic [9:0] ws,
			input logic [9:0] rmin, input logic [9:0] rmax);
		write_reg(owss_pkg::CFG_SAMPLE_DELAY, sd);
		write_reg(owss_pkg::CFG_READ_TAIL, rt);
		write_reg(owss_pkg::CFG_RELEASE_TIMEOUT, rto);
		write_reg(owss_pkg::CFG_ZERO_HOLD, zh);
		write_reg(owss_pkg::CFG_WRITE_SLOT, ws);
		write_reg(owss_pkg::CFG_RESET_MIN, rmin);
		write_reg(owss_pkg::CFG_RESET_MAX, rmax);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drain everything, then add clean slots until the engine is back to idle
	task automatic settle();
		int saved;
		saved = noise_pct;
		noise_pct = 0;
		while (1) begin
			while (bus_ticks.size() != 0 || slot_results.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
			if (eng_phase == owss_pkg::PH_IDLE)
				break;
			if (eng_phase == owss_pkg::PH_LOW)
				add_level(1'b1, 1);
			else
				add_pulse(1, slot_span() + 2);
		end
		noise_pct = saved;
	endtask

	// mostly complete commands with random slot timing, some resets and some junk
	task automatic random_traffic(input int n);
		int start, k;
		start = ticks_queued;
		while (ticks_queued - start < n) begin
			k = int'($urandom_range(0, 99));
			if (k < 55)
				add_command(3'($urandom_range(owss_pkg::CMD_READ, owss_pkg::CMD_MATCH)), 1'b1);
			else if (k < 75)
				add_pulse(pick_reset_len(), int'($urandom_range(1, 4)));
			else if (k < 85) begin
				repeat ($urandom_range(1, 10))
					add_tick(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				// command arriving in the middle of a low pulse
				add_level(1'b0, int'($urandom_range(1, 4)));
				add_command(3'($urandom_range(owss_pkg::CMD_READ, owss_pkg::CMD_MATCH)), 1'b0);
			end
		end
	endtask

	function automatic logic [9:0] with_junk(input int v);
		// upper bits that the 8-bit registers must drop
		return 10'(v) | (10'($urandom_range(0, 3)) << 8);
	endfunction

	initial begin : sequencer
		int rand_start;
		timing[owss_pkg::CFG_SAMPLE_DELAY] = {2'b00, owss_pkg::RST_SAMPLE_DELAY};
		timing[owss_pkg::CFG_READ_TAIL] = {2'b00, owss_pkg::RST_READ_TAIL};
		timing[owss_pkg::CFG_RELEASE_TIMEOUT] = owss_pkg::RST_RELEASE_TIMEOUT;
		timing[owss_pkg::CFG_ZERO_HOLD] = {2'b00, owss_pkg::RST_ZERO_HOLD};
		timing[owss_pkg::CFG_WRITE_SLOT] = {2'b00, owss_pkg::RST_WRITE_SLOT};
		timing[owss_pkg::CFG_RESET_MIN] = owss_pkg::RST_RESET_MIN;
		timing[owss_pkg::CFG_RESET_MAX] = owss_pkg::RST_RESET_MAX;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset timing: plain and unused modes, a short pulse, one match slot
		// reading a one and one reading a zero, and a pulse at the reset minimum
		add_tick(owss_pkg::CMD_TICK, 1'b1, 8'hFF, 1'b1);
		for (int m = int'(owss_pkg::CMD_MATCH) + 1; m < 8; m++)
			add_tick(3'(m), 1'b1, 8'h00, 1'b0);
		add_pulse(3, 1);
		add_tick(owss_pkg::CMD_MATCH, 1'b1, 8'h00, 1'b1);
		add_pulse(5, 50);
		add_tick(owss_pkg::CMD_MATCH, 1'b1, 8'hFF, 1'b1);
		add_pulse(20, 40);
		add_pulse(int'(owss_pkg::RST_RESET_MIN), 2);
		settle();

		// zero and minimum timing: directed corner requests
		load_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 10'd1);
		add_pulse(3, 1);
		add_level(1'b0, 1);
		add_tick(owss_pkg::CMD_WRITE, 1'b0, 8'h00, 1'b0);
		add_tick(owss_pkg::CMD_READ, 1'b1, 8'hFF, 1'b1);
		add_tick(owss_pkg::CMD_TICK, 1'b0, 8'hFF, 1'b1);
		add_tick(owss_pkg::CMD_MATCH, 1'b0, 8'h00, 1'b1);
		settle();
		add_tick(owss_pkg::CMD_WRITE, 1'b1, 8'hFF, 1'b1);
		add_tick(owss_pkg::CMD_TICK, 1'b0, 8'h00, 1'b0);
		settle();
		add_tick(owss_pkg::CMD_SEARCH, 1'b1, 8'h00, 1'b1);
		settle();
		add_tick(owss_pkg::CMD_MATCH, 1'b1, 8'hFF, 1'b0);
		settle();

		// every command and both reset bounds, then random traffic
		noise_pct = 2;
		for (int m = int'(owss_pkg::CMD_READ); m <= int'(owss_pkg::CMD_MATCH); m++)
			add_command(3'(m), 1'b1);
		add_pulse(1, 3);
		add_pulse(2, 3);
		settle();
		noise_pct = 3;
		random_traffic(100);
		settle();

		// random traffic over a series of small timing settings
		rand_start = ticks_queued;
		while (ticks_queued - rand_start < RANDOM_TICKS) begin
			load_timing(with_junk(int'($urandom_range(0, 6))),
				with_junk(int'($urandom_range(0, 6))),
				10'($urandom_range(0, 8)), with_junk(int'($urandom_range(0, 6))),
				with_junk(int'($urandom_range(0, 8))), 10'($urandom_range(1, 12)),
				10'($urandom_range(1, 16)));
			noise_pct = 3;
			random_traffic(RANDOM_BATCH);
			settle();
		end

		repeat (8) @(posedge clk);
		if (failures == 0 && slot_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// offer the oldest pending request; it stays up until accepted or an idle cycle
	always @(negedge clk) begin
		if (!arst_n || bus_ticks.size() == 0 || (!calm && $urandom_range(0, 99) < 8))
			push <= 1'b0;
		else begin
			push <= 1'b1;
			mode <= bus_ticks[0].mode;
			line <= bus_ticks[0].line;
			data_byte <= bus_ticks[0].data_byte;
			ref_bit <= bus_ticks[0].ref_bit;
		end
	end

	// result side: random pops, and one long hold-off so the request side backs up
	always @(negedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AT &&
				bus_ticks.size() >= HOLD_BACKLOG) begin
			pop <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else
			pop <= calm || $urandom_range(0, 99) >= 8;
	end

	// ---------------------------------------------------------------- monitor

	task automatic flag(input string what, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
			failures++;
		end
	endtask

	always @(posedge clk) begin : monitor
		owss_pkg::result_t want;
		owss_pkg::result_t next_res;
		tick_req_t         req;
		if (arst_n) begin
			cycle_no++;
			// popped result: the oldest prediction must match
			if (pop && !empty) begin
				results_seen++;
				if (slot_results.size() == 0) begin
					$display("%0t: result with nothing expected, event %0d", $time, event_res);
					failures++;
				end else begin
					want = slot_results.pop_front();
					flag("drive_low", int'(want.drive_low), int'(drive_low));
					flag("event_res", int'(want.event_res), int'(event_res));
					flag("rx_byte", int'(want.rx_byte), int'(rx_byte));
					flag("busy_res", int'(want.busy_res), int'(busy_res));
				end
			end
			// accepted request: step the prediction on what was on the ports
			if (push && !full) begin
				req.mode = mode;
				req.line = line;
				req.data_byte = data_byte;
				req.ref_bit = ref_bit;
				void'(bus_ticks.pop_front());
				engine_step(req, next_res);
				slot_results.push_back(next_res);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
